[rtl/pfdm_pkg.sv]
// Shared types, codes and sizes of the PWM frequency and duty meter.
package pfdm_pkg;

   // Widths of the item fields
   localparam int StampWidth  = 32;
   localparam int ModeWidth   = 2;
   localparam int StatusWidth = 2;
   localparam int FreqWidth   = 27;
   localparam int DutyWidth   = 7;
   localparam int TicksWidth  = 32;
   localparam int TimeoutWidth = 32;

   // Configuration port
   localparam int CsrNumRegs    = 2;
   localparam int CsrIndexWidth = $clog2(CsrNumRegs);
   localparam int CsrDataWidth  = 32;
   localparam logic [CsrIndexWidth-1:0] CSR_TICK_RATE = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CSR_TIMEOUT   = CsrIndexWidth'(1);
   localparam logic [FreqWidth-1:0]     TickRateReset = FreqWidth'(1000000);
   localparam logic [TimeoutWidth-1:0]  TimeoutReset  = TimeoutWidth'(1000000);

   // Item modes
   localparam logic [ModeWidth-1:0] MODE_TICK  = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_RISE  = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_FALL  = 2'd2;
   localparam logic [ModeWidth-1:0] MODE_START = 2'd3;

   // Capture phases; a timeout reports the phase code as its status
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_RISE1 = 2'd1;
   localparam logic [1:0] PH_FALL  = 2'd2;
   localparam logic [1:0] PH_RISE2 = 2'd3;

   // Result status codes
   localparam logic [StatusWidth-1:0] STATUS_OK          = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_TO_RISE1    = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_TO_FALL     = 2'd2;
   localparam logic [StatusWidth-1:0] STATUS_TO_RISE2    = 2'd3;

   // Duty scale and step counts of the back end
   localparam logic [DutyWidth-1:0] DutyScale = DutyWidth'(100);
   localparam int DutySteps  = 2 * DutyWidth;
   localparam int RunSteps   = (FreqWidth > DutySteps) ? FreqWidth : DutySteps;
   localparam int StepWidth  = $clog2(RunSteps);
   localparam int DutyIdxWidth = $clog2(DutyWidth);

   // Job queue between front and back
   localparam int QueueDepth = 2;
   localparam int QPtrWidth  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCntWidth  = $clog2(QueueDepth + 1);

   // One finished capture (or timeout) handed to the back end
   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [StampWidth-1:0]  period;
      logic [StampWidth-1:0]  high;
   } job_type;

endpackage

[rtl/pfdm_req_if.sv]
// Request channel: mode and time stamp of one event item.
interface pfdm_req_if;
   logic                           valid;
   logic                           ready;
   logic [pfdm_pkg::ModeWidth-1:0] mode;
   logic [pfdm_pkg::TicksWidth-1:0] stamp;

   modport source (output valid, output mode, output stamp, input ready);
   modport sink   (input valid, input mode, input stamp, output ready);
endinterface

[rtl/pfdm_rsp_if.sv]
// Response channel: status, frequency, duty, period and high time of one item.
interface pfdm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pfdm_pkg::StatusWidth-1:0]  status;
   logic [pfdm_pkg::FreqWidth-1:0]    freq_hz;
   logic [pfdm_pkg::DutyWidth-1:0]    duty_cycle;
   logic [pfdm_pkg::TicksWidth-1:0]   period_ticks;
   logic [pfdm_pkg::TicksWidth-1:0]   high_ticks;

   modport source (output valid, output status, output freq_hz, output duty_cycle,
                   output period_ticks, output high_ticks, input ready);
   modport sink   (input valid, input status, input freq_hz, input duty_cycle,
                   input period_ticks, input high_ticks, output ready);
endinterface

[rtl/pfdm_front.sv]
// Capture front end: phase sequencing, edge stamps, timeouts and job push.
module pfdm_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [pfdm_pkg::ModeWidth-1:0]       in_mode,
   input  logic [pfdm_pkg::TicksWidth-1:0]      in_stamp,
   input  logic [pfdm_pkg::TimeoutWidth-1:0]    timeout_ticks,
   output logic                                 push,
   output pfdm_pkg::job_type                    push_job
);

   logic [1:0]                          phase_ff, phase_in;
   logic [pfdm_pkg::StampWidth-1:0]     rise_ff, rise_in;
   logic [pfdm_pkg::StampWidth-1:0]     high_ff, high_in;
   logic [pfdm_pkg::TimeoutWidth-1:0]   wait_ff, wait_in;
   logic [pfdm_pkg::StampWidth-1:0]     stamp;
   logic [pfdm_pkg::StampWidth-1:0]     period;
   logic [pfdm_pkg::TimeoutWidth-1:0]   wait_inc;

   assign stamp    = pfdm_pkg::StampWidth'(in_stamp);
   assign period   = stamp - rise_ff;
   assign wait_inc = wait_ff + 1'b1;

   // Advance the capture phase on each accepted item
   always_comb begin
      phase_in = phase_ff;
      rise_in  = rise_ff;
      high_in  = high_ff;
      wait_in  = wait_ff;
      push     = 1'b0;
      push_job = '0;
      if (in_valid) begin
         if (in_mode == pfdm_pkg::MODE_START) begin
            phase_in = pfdm_pkg::PH_RISE1;
            wait_in  = '0;
         end else if (phase_ff != pfdm_pkg::PH_IDLE) begin
            unique case (in_mode)
               pfdm_pkg::MODE_TICK: begin
                  wait_in = wait_inc;
                  if (wait_inc >= timeout_ticks) begin
                     // phase code doubles as the timeout status
                     push            = 1'b1;
                     push_job.status = phase_ff;
                     phase_in        = pfdm_pkg::PH_IDLE;
                     wait_in         = '0;
                  end
               end
               pfdm_pkg::MODE_RISE: begin
                  if (phase_ff == pfdm_pkg::PH_RISE1) begin
                     rise_in  = stamp;
                     phase_in = pfdm_pkg::PH_FALL;
                     wait_in  = '0;
                  end else if (phase_ff == pfdm_pkg::PH_RISE2) begin
                     push            = 1'b1;
                     push_job.status = pfdm_pkg::STATUS_OK;
                     push_job.period = period;
                     push_job.high   = (high_ff > period) ? period : high_ff;
                     phase_in        = pfdm_pkg::PH_IDLE;
                     wait_in         = '0;
                  end
               end
               pfdm_pkg::MODE_FALL: begin
                  if (phase_ff == pfdm_pkg::PH_FALL) begin
                     high_in  = stamp - rise_ff;
                     phase_in = pfdm_pkg::PH_RISE2;
                     wait_in  = '0;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pfdm_pkg::PH_IDLE;
         wait_ff  <= '0;
         rise_ff  <= '0;
         high_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         rise_ff  <= rise_in;
         high_ff  <= high_in;
      end
   end

endmodule

[rtl/pfdm_queue.sv]
// Small job queue in flip-flops between the front and back ends.
module pfdm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfdm_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output pfdm_pkg::job_type head
);

   pfdm_pkg::job_type                   slot_ff [pfdm_pkg::QueueDepth];
   logic [pfdm_pkg::QPtrWidth-1:0]      wr_ff, wr_in;
   logic [pfdm_pkg::QPtrWidth-1:0]      rd_ff, rd_in;
   logic [pfdm_pkg::QCntWidth-1:0]      cnt_ff, cnt_in;

   localparam logic [pfdm_pkg::QPtrWidth-1:0] LastPtr =
      pfdm_pkg::QPtrWidth'(pfdm_pkg::QueueDepth - 1);

   assign full      = (cnt_ff == pfdm_pkg::QCntWidth'(pfdm_pkg::QueueDepth));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

[rtl/pfdm_back.sv]
// Result back end: iterative frequency and duty division, result register.
module pfdm_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             job_avail,
   input  pfdm_pkg::job_type                job,
   output logic                             pop,
   input  logic [pfdm_pkg::FreqWidth-1:0]   tick_rate_hz,
   pfdm_rsp_if.source                       rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   localparam int SW = pfdm_pkg::StampWidth;
   localparam int FW = pfdm_pkg::FreqWidth;
   localparam int DW = pfdm_pkg::DutyWidth;
   localparam logic [pfdm_pkg::StepWidth-1:0] LastStep =
      pfdm_pkg::StepWidth'(pfdm_pkg::RunSteps - 1);
   localparam logic [pfdm_pkg::StepWidth-1:0] DutyEnd =
      pfdm_pkg::StepWidth'(pfdm_pkg::DutySteps);
   localparam logic [pfdm_pkg::DutyIdxWidth-1:0] DutyTop =
      pfdm_pkg::DutyIdxWidth'(DW - 1);

   logic [1:0]                          state_ff, state_in;
   logic [pfdm_pkg::StepWidth-1:0]      step_ff, step_in;
   logic [pfdm_pkg::StatusWidth-1:0]    status_ff, status_in;
   logic [SW-1:0]                       per_ff, per_in;
   logic [SW-1:0]                       hi_ff, hi_in;
   logic [FW-1:0]                       quo_ff, quo_in;
   logic [SW-1:0]                       rem_ff, rem_in;
   logic [DW-1:0]                       dq_ff, dq_in;
   logic [SW-1:0]                       dr_ff, dr_in;

   logic [SW:0]                         trial;
   logic                                trial_ge;
   logic [SW-1:0]                       dbl_gap;
   logic [SW-1:0]                       add_gap;
   logic                                dbl_ge;
   logic                                add_ge;
   logic [pfdm_pkg::DutyIdxWidth-1:0]   duty_bit;

   // Frequency: one restoring quotient bit per step
   assign trial    = {rem_ff, quo_ff[FW-1]};
   assign trial_ge = (trial >= {1'b0, per_ff});

   // Duty: doubling on even steps, adding high time on odd steps for set scale bits
   assign dbl_gap  = per_ff - dr_ff;
   assign add_gap  = per_ff - hi_ff;
   assign dbl_ge   = (dr_ff >= dbl_gap);
   assign add_ge   = (dr_ff >= add_gap);
   assign duty_bit = DutyTop - step_ff[pfdm_pkg::DutyIdxWidth:1];

   assign pop = (state_ff == ST_IDLE) && job_avail;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      status_in = status_ff;
      per_in    = per_ff;
      hi_in     = hi_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dq_in     = dq_ff;
      dr_in     = dr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // load the next job; skip division for timeouts and zero period
            if (job_avail) begin
               status_in = job.status;
               per_in    = job.period;
               hi_in     = job.high;
               step_in   = '0;
               rem_in    = '0;
               dq_in     = '0;
               dr_in     = '0;
               if ((job.status != pfdm_pkg::STATUS_OK) || (job.period == '0)) begin
                  quo_in   = '0;
                  state_in = ST_HOLD;
               end else begin
                  quo_in   = tick_rate_hz;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (step_ff < pfdm_pkg::StepWidth'(FW)) begin
               quo_in = {quo_ff[FW-2:0], trial_ge};
               rem_in = trial_ge ? SW'(trial - {1'b0, per_ff}) : trial[SW-1:0];
            end
            if (step_ff < DutyEnd) begin
               if (!step_ff[0]) begin
                  dq_in = {dq_ff[DW-2:0], dbl_ge};
                  dr_in = dbl_ge ? (dr_ff - dbl_gap) : {dr_ff[SW-2:0], 1'b0};
               end else if (pfdm_pkg::DutyScale[duty_bit]) begin
                  dq_in = dq_ff + DW'(add_ge);
                  dr_in = add_ge ? (dr_ff - add_gap) : (dr_ff + hi_ff);
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LastStep) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      status_ff <= status_in;
      per_ff    <= per_in;
      hi_ff     <= hi_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dq_ff     <= dq_in;
      dr_ff     <= dr_in;
   end

   // Drive the result from its registers
   assign rsp.valid        = (state_ff == ST_HOLD);
   assign rsp.status       = status_ff;
   assign rsp.freq_hz      = quo_ff;
   assign rsp.duty_cycle   = dq_ff;
   assign rsp.period_ticks = pfdm_pkg::TicksWidth'(per_ff);
   assign rsp.high_ticks   = pfdm_pkg::TicksWidth'(hi_ff);

   // Duty never exceeds full scale
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.duty_cycle <= pfdm_pkg::DutyScale))
      else $error("duty above full scale");

   // High time is clamped to the period
   a_high_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.high_ticks <= rsp.period_ticks))
      else $error("high time above period");

   // Timeout results carry no measurement
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status != pfdm_pkg::STATUS_OK)) |->
      ((rsp.freq_hz == '0) && (rsp.duty_cycle == '0) && (rsp.period_ticks == '0)))
      else $error("timeout result carries data");

   // A job is taken only when the back end is free
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ST_RUN || state_ff == ST_HOLD))
      else $error("job popped without starting");

endmodule

[rtl/pwm_frequency_duty_meter_unit.sv]
// Top level of the PWM frequency and duty meter: registers, front, queue, back.
//
//   channel  | dir | handshake        | payload
//   req_ch   | in  | valid / ready    | mode, stamp
//   rsp_ch   | out | valid / ready    | status, freq_hz, duty_cycle, period_ticks,
//            |     |                  | high_ticks
//   csr_*    | in  | csr_we           | csr_index, csr_wdata
//
// The front end takes one item per cycle while the job queue has room.
// A finished capture is loaded, then runs RunSteps (27) steps in the shared divider of the
// back end before its result is held; timeouts and zero periods skip the steps.
// Reset is synchronous and clears phase, queue and result state; registers
// return to 1000000. A stalled result holds the back end, which stalls the queue,
// which then lowers req_ch.ready.
module pwm_frequency_duty_meter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   pfdm_req_if.sink                             req_ch,
   pfdm_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [pfdm_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [pfdm_pkg::CsrDataWidth-1:0]    csr_wdata
);

   logic [pfdm_pkg::FreqWidth-1:0]     tick_rate_ff;
   logic [pfdm_pkg::TimeoutWidth-1:0]  timeout_ff;
   logic                               q_full;
   logic                               q_not_empty;
   logic                               push;
   logic                               pop;
   pfdm_pkg::job_type                  push_job;
   pfdm_pkg::job_type                  head_job;

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= pfdm_pkg::TickRateReset;
         timeout_ff   <= pfdm_pkg::TimeoutReset;
      end else if (csr_we) begin
         unique case (csr_index)
            pfdm_pkg::CSR_TICK_RATE: tick_rate_ff <= csr_wdata[pfdm_pkg::FreqWidth-1:0];
            pfdm_pkg::CSR_TIMEOUT:   timeout_ff   <= pfdm_pkg::TimeoutWidth'(csr_wdata);
            default: begin
               timeout_ff <= timeout_ff;
            end
         endcase
      end
   end

   // Accept items while the queue has room
   assign req_ch.ready = !q_full;

   pfdm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_ch.valid && !q_full),
      .in_mode       (req_ch.mode),
      .in_stamp      (req_ch.stamp),
      .timeout_ticks (timeout_ff),
      .push          (push),
      .push_job      (push_job)
   );

   pfdm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head_job)
   );

   pfdm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_avail    (q_not_empty),
      .job          (head_job),
      .pop          (pop),
      .tick_rate_hz (tick_rate_ff),
      .rsp          (rsp_ch)
   );

endmodule

[tb/tb_pwm_frequency_duty_meter_unit.sv]
// Self-checking testbench of the PWM frequency and duty meter unit.
`timescale 1ns / 100ps

module tb_pwm_frequency_duty_meter_unit;
   import pfdm_pkg::*;

   localparam int CycleLimit   = 300000;
   localparam int SettleCycles = 40;
   localparam int RandomItems  = 600;
   localparam int PhaseItems   = 100;

   // One reading as it leaves the result channel
   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [FreqWidth-1:0]   freq_hz;
      logic [DutyWidth-1:0]   duty_cycle;
      logic [TicksWidth-1:0]  period_ticks;
      logic [TicksWidth-1:0]  high_ticks;
   } meter_reading_t;

   // Tracks the capture state and the readings still owed by the block
   class capture_tracker;
      logic [FreqWidth-1:0]    tick_rate;
      logic [TimeoutWidth-1:0] timeout_limit;
      logic [1:0]              cap_phase;
      logic [StampWidth-1:0]   rise_stamp;
      logic [StampWidth-1:0]   fall_stamp;
      logic [TimeoutWidth-1:0] tick_count;
      meter_reading_t          readings_due[$];
      int                      fail_count;

      function new();
         tick_rate     = TickRateReset;
         timeout_limit = TimeoutReset;
         cap_phase     = PH_IDLE;
         rise_stamp    = '0;
         fall_stamp    = '0;
         tick_count    = '0;
         fail_count    = 0;
      endfunction

      function void set_reg(logic [CsrIndexWidth-1:0] index, logic [CsrDataWidth-1:0] value);
         if (index == CSR_TICK_RATE) tick_rate = value[FreqWidth-1:0];
         else if (index == CSR_TIMEOUT) timeout_limit = value[TimeoutWidth-1:0];
      endfunction

      function void note_fail(string what);
         if (fail_count < 10) $display("%s", what);
         fail_count++;
      endfunction

      // Advance the capture by one item; return 1 unless the item is ignored
      function bit absorb_item(logic [ModeWidth-1:0] mode, logic [StampWidth-1:0] stamp);
         meter_reading_t   r;
         logic [StampWidth-1:0] per;
         logic [StampWidth-1:0] hi;
         longint unsigned  scaled;
         r = '0;
         if (mode == MODE_START) begin
            cap_phase  = PH_RISE1;
            tick_count = '0;
            return 1'b1;
         end
         if (cap_phase == PH_IDLE) return 1'b0;
         case (mode)
            MODE_TICK: begin
               tick_count = tick_count + 1'b1;
               if (tick_count >= timeout_limit) begin
                  r.status = cap_phase;
                  readings_due.push_back(r);
                  cap_phase  = PH_IDLE;
                  tick_count = '0;
               end
               return 1'b1;
            end
            MODE_RISE: begin
               if (cap_phase == PH_RISE1) begin
                  rise_stamp = stamp;
                  cap_phase  = PH_FALL;
                  tick_count = '0;
                  return 1'b1;
               end
               if (cap_phase != PH_RISE2) return 1'b0;
               // Close the capture: wrapped differences, high time clamped
               per = stamp - rise_stamp;
               hi  = fall_stamp - rise_stamp;
               if (hi > per) hi = per;
               r.status       = STATUS_OK;
               r.period_ticks = per;
               r.high_ticks   = hi;
               if (per != 0) begin
                  r.freq_hz    = FreqWidth'(64'(tick_rate) / 64'(per));
                  scaled       = 64'(hi) * 64'(DutyScale);
                  r.duty_cycle = DutyWidth'(scaled / 64'(per));
               end
               readings_due.push_back(r);
               cap_phase  = PH_IDLE;
               tick_count = '0;
               return 1'b1;
            end
            default: begin
               if (cap_phase != PH_FALL) return 1'b0;
               fall_stamp = stamp;
               cap_phase  = PH_RISE2;
               tick_count = '0;
               return 1'b1;
            end
         endcase
      endfunction

      // Compare one reading with the oldest one owed
      function void check_reading(meter_reading_t got);
         meter_reading_t want;
         if (readings_due.size() == 0) begin
            note_fail($sformatf("unexpected reading: status=%0d freq=%0d duty=%0d period=%h high=%h",
                                got.status, got.freq_hz, got.duty_cycle, got.period_ticks,
                                got.high_ticks));
            return;
         end
         want = readings_due.pop_front();
         if (got.status !== want.status || got.freq_hz !== want.freq_hz ||
             got.duty_cycle !== want.duty_cycle || got.period_ticks !== want.period_ticks ||
             got.high_ticks !== want.high_ticks) begin
            note_fail($sformatf({"reading mismatch: got status=%0d freq=%0d duty=%0d ",
                                 "period=%h high=%h\n",
                                 "                 want status=%0d freq=%0d duty=%0d ",
                                 "period=%h high=%h"},
                                got.status, got.freq_hz, got.duty_cycle, got.period_ticks,
                                got.high_ticks, want.status, want.freq_hz, want.duty_cycle,
                                want.period_ticks, want.high_ticks));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   pfdm_req_if req_ch ();
   pfdm_rsp_if rsp_ch ();

   pwm_frequency_duty_meter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   capture_tracker tracker;
   int used_items;
   int cycle_count;
   bit send_gaps_on;
   bit take_gaps_on;

   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Present one item and hold it until the block takes it
   task automatic send_item(input logic [ModeWidth-1:0] mode, input logic [StampWidth-1:0] stamp);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= mode;
      req_ch.stamp <= stamp;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (tracker.absorb_item(mode, stamp)) used_items++;
   endtask

   // Drop valid, wait for every owed reading, then let the back end drain
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.readings_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      tracker.set_reg(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // One start followed by rise, fall and rise, with ticks and stray edges mixed in
   task automatic run_capture();
      logic [StampWidth-1:0] first_rise;
      logic [StampWidth-1:0] period;
      logic [StampWidth-1:0] high_time;
      logic [StampWidth-1:0] edge_stamp[3];
      logic [ModeWidth-1:0]  edge_mode[3];
      int n;
      int cap;
      first_rise = $urandom;
      case ($urandom_range(0, 5))
         0: period = '0;
         1: period = $urandom_range(1, 200);
         2: period = $urandom_range(1, 1 << 20);
         3: period = 32'hFFFF_FFFF;
         default: period = $urandom;
      endcase
      case ($urandom_range(0, 4))
         0: high_time = '0;
         1: high_time = period;
         2: high_time = period + $urandom_range(1, 1000);
         default: high_time = 32'((64'(period) * $urandom_range(0, 100)) / 100);
      endcase
      edge_stamp[0] = first_rise;
      edge_stamp[1] = first_rise + high_time;
      edge_stamp[2] = first_rise + period;
      edge_mode[0]  = MODE_RISE;
      edge_mode[1]  = MODE_FALL;
      edge_mode[2]  = MODE_RISE;
      cap = (tracker.timeout_limit <= 8) ? int'(tracker.timeout_limit) + 1 : 3;
      send_item(MODE_START, $urandom);
      for (int k = 0; k < 3; k++) begin
         // wrong kind of edge for this phase
         if ($urandom_range(0, 4) == 0) send_item((k == 1) ? MODE_RISE : MODE_FALL, $urandom);
         n = $urandom_range(0, cap);
         repeat (n) send_item(MODE_TICK, $urandom);
         // abandon; the next start rearms a busy block
         if ($urandom_range(0, 24) == 0) return;
         send_item(edge_mode[k], edge_stamp[k]);
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) send_item(ModeWidth'($urandom_range(0, 3)), $urandom);
      end
   endtask

   // Accept readings with random stalls and check each one
   initial begin : take_readings
      meter_reading_t got;
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = take_gaps_on ? $urandom_range(0, 4) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got.status       = rsp_ch.status;
         got.freq_hz      = rsp_ch.freq_hz;
         got.duty_cycle   = rsp_ch.duty_cycle;
         got.period_ticks = rsp_ch.period_ticks;
         got.high_ticks   = rsp_ch.high_ticks;
         tracker.check_reading(got);
      end
   end

   initial begin : stimulus
      logic [CsrDataWidth-1:0] rate;
      logic [CsrDataWidth-1:0] limit;
      int phase_idx;
      int target;
      tracker      = new();
      used_items   = 0;
      cycle_count  = 0;
      send_gaps_on = 1'b1;
      take_gaps_on = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode  = MODE_TICK;
      req_ch.stamp = '0;
      rsp_ch.ready = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_TICK_RATE;
      csr_wdata    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: fastest tick rate, timeout on the first tick
      write_reg(CSR_TICK_RATE, 100000000);
      write_reg(CSR_TIMEOUT, 1);
      // idle block ignores ticks and edges
      send_item(MODE_TICK, 32'hFFFF_FFFF);
      send_item(MODE_FALL, 32'h0000_0000);
      // stray fall, second rise, second fall; stamps wrap
      send_item(MODE_START, 32'h0000_0000);
      send_item(MODE_FALL, 32'h0000_AAAA);
      send_item(MODE_RISE, 32'hFFFF_FFF0);
      send_item(MODE_RISE, 32'h0000_0005);
      send_item(MODE_FALL, 32'h0000_0010);
      send_item(MODE_FALL, 32'h0000_0020);
      send_item(MODE_RISE, 32'h0000_0030);
      // fall before the rise gives a high time past the period
      send_item(MODE_START, 32'h5555_5555);
      send_item(MODE_RISE, 32'd100);
      send_item(MODE_FALL, 32'd50);
      send_item(MODE_RISE, 32'd200);
      // start while busy, then a zero period
      send_item(MODE_START, 32'h0);
      send_item(MODE_RISE, 32'd9);
      send_item(MODE_START, 32'h0);
      send_item(MODE_RISE, 32'd7);
      send_item(MODE_FALL, 32'd7);
      send_item(MODE_RISE, 32'd7);
      // timeout in each waiting phase
      send_item(MODE_START, 32'h0);
      send_item(MODE_TICK, 32'h0);
      send_item(MODE_START, 32'h0);
      send_item(MODE_RISE, 32'h1234_5678);
      send_item(MODE_TICK, 32'h0);
      send_item(MODE_START, 32'h0);
      send_item(MODE_RISE, 32'h8000_0000);
      send_item(MODE_FALL, 32'h8000_0001);
      send_item(MODE_TICK, 32'h0);

      // Random phases, each under its own register setting
      used_items = 0;
      phase_idx  = 0;
      while (used_items < RandomItems) begin
         settle();
         case (phase_idx)
            0: begin rate = 100000000; limit = 32'hFFFF_FFFF; end
            1: begin rate = 1; limit = 1; end
            2: begin rate = 1000000; limit = 0; end
            3: begin rate = 100000000; limit = $urandom_range(2, 8); end
            default: begin
               rate  = $urandom_range(1, 100000000);
               limit = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 10);
            end
         endcase
         write_reg(CSR_TIMEOUT, limit);
         write_reg(CSR_TICK_RATE, rate);
         send_gaps_on = ($urandom_range(0, 3) != 0);
         take_gaps_on = ($urandom_range(0, 3) != 0);
         target = used_items + PhaseItems;
         while (used_items < target && used_items < RandomItems) run_capture();
         phase_idx++;
      end
      settle();

      if (tracker.fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
